/* rtl/sfp_pkg.sv */
package sfp_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_SUM  = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_END = 2'd2
  } frame_status_t;

  // Registered input byte with its valid flag
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [7:0] frame_length;
  } res_t;

endpackage

/* rtl/sfp_if.sv */
interface sfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [7:0] payload_index;
  logic       frame_done;
  logic [1:0] frame_status;
  logic [7:0] frame_length;

  modport source (
    output valid, output payload_byte, output payload_valid, output payload_index,
    output frame_done, output frame_status, output frame_length, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_valid, input payload_index,
    input frame_done, input frame_status, input frame_length, output ready
  );
endinterface

/* rtl/sfp_in_reg.sv */
module sfp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_ready,
  input  logic           advance,
  output sfp_pkg::stage_t stage
);

  logic       valid_r;
  logic [7:0] data_r;

  // Take a new byte when empty or when the held byte moves on this cycle
  assign in_ready = !valid_r || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

/* rtl/sfp_parse_core.sv */
module sfp_parse_core (
  input  logic            clk,
  input  logic            rst_n,
  input  sfp_pkg::stage_t stage,
  input  logic            advance,
  output sfp_pkg::res_t   res
);

  sfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [7:0]      cnt_inc;
  logic [7:0]      b;

  assign b       = stage.data;
  assign cnt_inc = cnt_r + 8'd1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      sfp_pkg::PH_HUNT: begin
        if (b == sfp_pkg::START_BYTE) phase_nxt = sfp_pkg::PH_LEN;
      end
      sfp_pkg::PH_LEN:  phase_nxt = sfp_pkg::PH_DATA;
      sfp_pkg::PH_DATA: begin
        if (cnt_inc >= len_r) phase_nxt = sfp_pkg::PH_SUM;
      end
      sfp_pkg::PH_SUM: begin
        phase_nxt = (sum_r == b) ? sfp_pkg::PH_END : sfp_pkg::PH_HUNT;
      end
      sfp_pkg::PH_END:  phase_nxt = sfp_pkg::PH_HUNT;
      default:          phase_nxt = sfp_pkg::PH_HUNT;
    endcase
  end

  // Result and datapath state
  always_comb begin
    len_nxt = len_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    res     = '0;
    unique case (phase_r)
      sfp_pkg::PH_HUNT: begin
        if (b == sfp_pkg::START_BYTE) begin
          len_nxt = 8'd0;
          sum_nxt = 8'd0;
          cnt_nxt = 8'd0;
        end
      end
      sfp_pkg::PH_LEN: begin
        len_nxt = b;
        sum_nxt = sum_r + b;
      end
      sfp_pkg::PH_DATA: begin
        res.payload_byte  = b;
        res.payload_valid = 1'b1;
        res.payload_index = cnt_r;
        sum_nxt           = sum_r + b;
        cnt_nxt           = cnt_inc;
      end
      sfp_pkg::PH_SUM: begin
        if (sum_r != b) begin
          res.frame_done   = 1'b1;
          res.frame_status = sfp_pkg::ST_BAD_SUM;
          res.frame_length = len_r;
        end
      end
      sfp_pkg::PH_END: begin
        res.frame_done   = 1'b1;
        res.frame_status = (b == sfp_pkg::END_BYTE) ? sfp_pkg::ST_GOOD : sfp_pkg::ST_BAD_END;
        res.frame_length = len_r;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Advance state once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfp_pkg::PH_HUNT;
      len_r   <= 8'd0;
      sum_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* rtl/sfp_out_reg.sv */
module sfp_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  sfp_pkg::res_t res,
  input  logic          out_ready,
  output logic          can_load,
  output logic          out_valid,
  output sfp_pkg::res_t out_res
);

  logic          valid_r;
  sfp_pkg::res_t res_r;

  // Load when empty or when the held result leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/stx_etx_frame_parser.sv */
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid / ready | rx_byte[7:0]
// out_ch   | out | valid / ready | payload_byte, payload_valid, payload_index,
//          |     |               | frame_done, frame_status, frame_length
//
// One byte per cycle sustained while out_ch.ready stays high; every byte yields exactly one result.
// Each byte passes the input register, then parse logic into the result register.
// Synchronous active-low reset returns the parser to hunting for a start byte.
// A stalled result register holds the input register, which then holds in_ch.ready low.
module stx_etx_frame_parser (
  input logic      clk,
  input logic      rst_n,
  sfp_byte_if.sink   in_ch,
  sfp_res_if.source  out_ch
);

  sfp_pkg::stage_t stage;
  sfp_pkg::res_t   res;
  sfp_pkg::res_t   out_res;
  logic            advance;
  logic            can_load;

  // Move the held byte into the parser when the result register can take it
  assign advance = stage.valid && can_load;

  sfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .advance  (advance),
    .stage    (stage)
  );

  sfp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .res     (res)
  );

  sfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .out_ready (out_ch.ready),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.payload_valid = out_res.payload_valid;
  assign out_ch.payload_index = out_res.payload_index;
  assign out_ch.frame_done    = out_res.frame_done;
  assign out_ch.frame_status  = out_res.frame_status;
  assign out_ch.frame_length  = out_res.frame_length;

  // No result before the first byte after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A byte is either payload or a frame end, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.payload_valid && out_ch.frame_done))
    else $error("payload and frame end in one result");

  // Frame fields stay clear on results that end no frame
  a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.frame_done) |->
      (out_ch.frame_status == sfp_pkg::ST_GOOD && out_ch.frame_length == 8'd0))
    else $error("frame fields set without frame end");

  // Payload fields stay clear on non-payload results
  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.payload_valid) |->
      (out_ch.payload_byte == 8'd0 && out_ch.payload_index == 8'd0))
    else $error("payload fields set without payload");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int BYTE_TARGET    = 1250;
  localparam int CALM_AFTER     = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PRINT_CAP      = 40;

  typedef logic [7:0] byte_q_t[$];

  typedef enum {FAULT_NONE, FAULT_SUM, FAULT_END} frame_fault_t;

  // Track parser state and compare each result transaction against the oldest prediction
  class frame_scoreboard;
    sfp_pkg::phase_t phase;
    logic [7:0]      frame_len;
    logic [7:0]      sum;
    logic [7:0]      count;
    sfp_pkg::res_t   pending_results[$];
    int              errors;
    int              n_payload;
    int              n_good;
    int              n_bad_sum;
    int              n_bad_end;

    function new();
      phase     = sfp_pkg::PH_HUNT;
      frame_len = '0;
      sum       = '0;
      count     = '0;
      errors    = 0;
      n_payload = 0;
      n_good    = 0;
      n_bad_sum = 0;
      n_bad_end = 0;
    endfunction

    // Advance the parser by one byte and return the result it should produce
    function sfp_pkg::res_t parse_byte(logic [7:0] b);
      sfp_pkg::res_t r;
      r = '0;
      case (phase)
        sfp_pkg::PH_HUNT: begin
          if (b == sfp_pkg::START_BYTE) begin
            sum       = '0;
            frame_len = '0;
            count     = '0;
            phase     = sfp_pkg::PH_LEN;
          end
        end
        sfp_pkg::PH_LEN: begin
          frame_len = b;
          sum       = sum + b;
          phase     = sfp_pkg::PH_DATA;
        end
        sfp_pkg::PH_DATA: begin
          r.payload_byte  = b;
          r.payload_valid = 1'b1;
          r.payload_index = count;
          sum             = sum + b;
          count           = count + 8'd1;
          // a zero length still takes one payload byte
          if (count >= frame_len) phase = sfp_pkg::PH_SUM;
        end
        sfp_pkg::PH_SUM: begin
          if (sum == b) begin
            phase = sfp_pkg::PH_END;
          end else begin
            r.frame_done   = 1'b1;
            r.frame_status = sfp_pkg::ST_BAD_SUM;
            r.frame_length = frame_len;
            phase          = sfp_pkg::PH_HUNT;
          end
        end
        sfp_pkg::PH_END: begin
          r.frame_done   = 1'b1;
          r.frame_status = (b == sfp_pkg::END_BYTE) ? sfp_pkg::ST_GOOD
                                                    : sfp_pkg::ST_BAD_END;
          r.frame_length = frame_len;
          phase          = sfp_pkg::PH_HUNT;
        end
        default: begin
          phase = sfp_pkg::PH_HUNT;
        end
      endcase
      return r;
    endfunction

    // Note an accepted input byte
    function void note_byte(logic [7:0] b);
      pending_results.push_back(parse_byte(b));
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // Check one result transaction field by field
    task check_result(sfp_pkg::res_t got);
      sfp_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no prediction pending");
        return;
      end
      want = pending_results.pop_front();
      if (got.payload_byte != want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, predicted %02h",
                                  got.payload_byte, want.payload_byte));
      if (got.payload_valid != want.payload_valid)
        report_mismatch($sformatf("payload_valid %0b, predicted %0b",
                                  got.payload_valid, want.payload_valid));
      if (got.payload_index != want.payload_index)
        report_mismatch($sformatf("payload_index %0d, predicted %0d",
                                  got.payload_index, want.payload_index));
      if (got.frame_done != want.frame_done)
        report_mismatch($sformatf("frame_done %0b, predicted %0b",
                                  got.frame_done, want.frame_done));
      if (got.frame_status != want.frame_status)
        report_mismatch($sformatf("frame_status %0d, predicted %0d",
                                  got.frame_status, want.frame_status));
      if (got.frame_length != want.frame_length)
        report_mismatch($sformatf("frame_length %0d, predicted %0d",
                                  got.frame_length, want.frame_length));
      if (want.payload_valid) n_payload++;
      if (want.frame_done) begin
        if (want.frame_status == sfp_pkg::ST_GOOD) n_good++;
        else if (want.frame_status == sfp_pkg::ST_BAD_SUM) n_bad_sum++;
        else n_bad_end++;
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idling;
  int   bytes_sent;
  int   idle_cycles;
  int   stall_left;

  frame_scoreboard sb;

  sfp_byte_if in_ch();
  sfp_res_if  out_ch();

  stx_etx_frame_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    idling       = 1'b1;
    bytes_sent   = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    sb           = new();
  end

  always #CLK_HALF clk = ~clk;

  // Stall the result channel in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Sample both channels and run the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{payload_byte:  out_ch.payload_byte,
                          payload_valid: out_ch.payload_valid,
                          payload_index: out_ch.payload_index,
                          frame_done:    out_ch.frame_done,
                          frame_status:  out_ch.frame_status,
                          frame_length:  out_ch.frame_length});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Present one byte, with an optional gap ahead of it, and hold until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'($urandom);
      end
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send start, length, body and checksum, then a closing byte unless the checksum is spoiled
  task automatic send_frame(input logic [7:0] len, input byte_q_t body,
                            input frame_fault_t fault);
    logic [7:0] chk;
    logic [7:0] tail;
    chk = len;
    foreach (body[i]) chk = chk + body[i];
    send_byte(sfp_pkg::START_BYTE);
    send_byte(len);
    foreach (body[i]) send_byte(body[i]);
    if (fault == FAULT_SUM) begin
      send_byte(chk + 8'($urandom_range(1, 255)));
    end else begin
      send_byte(chk);
      tail = sfp_pkg::END_BYTE;
      if (fault == FAULT_END) begin
        do tail = 8'($urandom); while (tail == sfp_pkg::END_BYTE);
      end
      send_byte(tail);
    end
  endtask

  initial begin
    byte_q_t      body;
    logic [7:0]   len;
    frame_fault_t fault;
    int           pick;
    int           roll;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bytes ignored while hunting, including the end byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sfp_pkg::END_BYTE);
    // zero length frame, which still carries one payload byte
    send_frame(8'h00, '{8'hFF}, FAULT_NONE);
    // start byte as payload, checksum equal to the end byte
    send_frame(8'h01, '{sfp_pkg::START_BYTE}, FAULT_NONE);
    // checksum mismatch drops back to hunting
    send_frame(8'h02, '{8'hAA, 8'h55}, FAULT_SUM);
    // wrong closing byte
    send_frame(8'h01, '{8'h80}, FAULT_END);

    // Random: mostly well-formed frames, some noise and truncated frames
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent > CALM_AFTER) idling = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 39) == 0)
          len = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(128, 254));
        else
          len = 8'($urandom_range(0, 10));
        body.delete();
        repeat ((len == 0) ? 1 : len) body.push_back(8'($urandom));
        roll = $urandom_range(0, 9);
        if (roll == 0) fault = FAULT_SUM;
        else if (roll == 1) fault = FAULT_END;
        else fault = FAULT_NONE;
        send_frame(len, body, fault);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_byte(sfp_pkg::START_BYTE);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes; checked %0d payload bytes and %0d frame endings",
             bytes_sent, sb.n_payload, sb.n_good + sb.n_bad_sum + sb.n_bad_end);
    $display("frame endings: %0d good, %0d checksum mismatch, %0d bad end byte; %0d errors",
             sb.n_good, sb.n_bad_sum, sb.n_bad_end, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sfp_pkg.sv
rtl/sfp_if.sv
rtl/sfp_in_reg.sv
rtl/sfp_parse_core.sv
rtl/sfp_out_reg.sv
rtl/stx_etx_frame_parser.sv
sim/tb.sv
